// ===== sv/tsvg_pkg.sv =====
package tsvg_pkg;

    // Field and count widths.
    localparam int POS_W   = 10;
    localparam int CNT_W   = 11;
    localparam int RAD_W   = 16;
    localparam int ANG_W   = 16;
    localparam int FRAC_W  = 12;
    localparam int OUT_W   = 18;
    localparam int SIN_W   = 14;
    localparam int K_W     = 21;
    localparam int REM_W   = 21;
    localparam int DIV_LEN = K_W + ANG_W;

    // Count limits.
    localparam logic [CNT_W-1:0] CNT_MIN    = 11'd4;
    localparam logic [CNT_W-1:0] MAX_WRAPS  = 11'd1024;
    localparam logic [CNT_W-1:0] MAX_SEGS   = 11'd1024;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WRAP  = 2'd0;
    localparam logic [1:0] REG_SEGS  = 2'd1;
    localparam logic [1:0] REG_MAJOR = 2'd2;
    localparam logic [1:0] REG_MINOR = 2'd3;

    // Sine polynomial coefficients in Q30.
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [31:0] K1 = 32'sd1686629713;
    localparam logic signed [31:0] K3 = 32'sd693598669;
    localparam logic signed [31:0] K5 = 32'sd85569306;
    localparam logic signed [31:0] K7 = 32'sd5026994;
    localparam logic signed [31:0] K9 = 32'sd172274;

    localparam logic signed [47:0] OUT_MAX = 48'sd131071;
    localparam logic signed [47:0] OUT_MIN = -48'sd131072;

    // One vertex request from the sequencer.
    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [POS_W-1:0] b;
        logic             last;
    } t_vtx_req;

    typedef enum logic [3:0] {
        BK_IDLE, BK_LOAD, BK_DIV, BK_SIN, BK_RAD, BK_Y, BK_X, BK_Z, BK_PUT
    } t_back_state;

    // Clamp a written count into its legal range.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [31:0] v,
                                                     input logic [CNT_W-1:0] hi);
        if (v < 32'(CNT_MIN)) begin
            return CNT_MIN;
        end else if (v > 32'(hi)) begin
            return hi;
        end
        return v[CNT_W-1:0];
    endfunction

    // Saturate to the signed output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [47:0] v);
        if (v > OUT_MAX) begin
            return OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            return OUT_MIN[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    // Q30 product truncated toward zero.
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        logic [63:0]        mag;
        p = a * b;
        if (p >= 0) begin
            mag = 64'(p) >> 30;
            return mag[31:0];
        end
        mag = 64'(-p) >> 30;
        return -$signed(mag[31:0]);
    endfunction

endpackage

// ===== sv/tsvg_front.sv =====
module tsvg_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_restart,
    input  logic [tsvg_pkg::CNT_W-1:0] i_wrap_count,
    input  logic [tsvg_pkg::CNT_W-1:0] i_seg_count,
    input  logic                      i_full,
    output logic                      o_push,
    output tsvg_pkg::t_vtx_req        o_req
);
    import tsvg_pkg::*;

    localparam logic [1:0] PH_MAIN  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_LAST  = 2'd2;
    localparam logic [1:0] PH_BAD   = 2'd3;

    logic [POS_W-1:0] r_wpos, n_wpos, r_spos, n_spos, ew, es;
    logic             r_half, n_half, eh, go;
    logic [1:0]       r_phase, n_phase, ep;
    logic [CNT_W-1:0] s_next, w_next;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Step the strip position for each transfer.
    always_comb begin
        go     = i_restart || (r_phase == PH_BAD);
        ew     = go ? '0 : r_wpos;
        es     = go ? '0 : r_spos;
        eh     = go ? 1'b0 : r_half;
        ep     = go ? PH_MAIN : r_phase;
        s_next = {1'b0, es} + 1'b1;
        w_next = {1'b0, ew} + 1'b1;
        n_wpos = ew;
        n_spos = es;
        n_half = eh;
        n_phase = ep;
        o_req  = '{a: {1'b0, ew} + CNT_W'(eh), b: es, last: 1'b0};
        case (ep)
            PH_FIRST: begin
                o_req   = '{a: '0, b: '0, last: 1'b0};
                n_phase = PH_LAST;
            end
            PH_LAST: begin
                o_req   = '{a: CNT_W'(1), b: '0, last: 1'b1};
                n_wpos  = '0;
                n_spos  = '0;
                n_half  = 1'b0;
                n_phase = PH_MAIN;
            end
            default: begin
                if (!eh) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_spos = s_next[POS_W-1:0];
                    if (s_next >= i_seg_count) begin
                        n_spos = '0;
                        n_wpos = w_next[POS_W-1:0];
                        if (w_next >= i_wrap_count) begin
                            n_wpos  = '0;
                            n_phase = PH_FIRST;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_spos  <= '0;
            r_half  <= 1'b0;
            r_phase <= PH_MAIN;
        end else if (o_push) begin
            r_wpos  <= n_wpos;
            r_spos  <= n_spos;
            r_half  <= n_half;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== sv/tsvg_queue.sv =====
module tsvg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsvg_pkg::t_vtx_req i_req,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_nonempty,
    output tsvg_pkg::t_vtx_req o_req
);
    import tsvg_pkg::*;

    t_vtx_req   r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_req      = r_mem[r_rd];

    // Storage for queued requests.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== sv/tsvg_back.sv =====
module tsvg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  tsvg_pkg::t_vtx_req                i_req,
    output logic                              o_pop,
    input  logic [tsvg_pkg::CNT_W-1:0]        i_wrap_count,
    input  logic [tsvg_pkg::CNT_W-1:0]        i_seg_count,
    input  logic [tsvg_pkg::RAD_W-1:0]        i_major,
    input  logic [tsvg_pkg::RAD_W-1:0]        i_minor,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_x,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_y,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_z,
    output logic                              o_strip_end
);
    import tsvg_pkg::*;

    t_back_state r_state, n_state;

    logic [CNT_W-1:0]        r_a;
    logic [POS_W-1:0]        r_b;
    logic                    r_last;
    logic [DIV_LEN-1:0]      r_d1, r_d2;
    logic [REM_W-1:0]        r_rem1, r_rem2, r_wn;
    logic [ANG_W-1:0]        r_q1, r_q2;
    logic [5:0]              r_cnt;
    logic [1:0]              r_sidx;
    logic [2:0]              r_step;
    logic signed [31:0]      r_t2, r_p, r_r;
    logic signed [SIN_W-1:0] r_sin [4];
    logic signed [OUT_W-1:0] r_x, r_y, r_z;
    logic                    r_ovalid;

    logic [K_W-1:0]          k_comb;
    logic [REM_W:0]          sh1, sh2, dv1, dv2;
    logic [ANG_W-1:0]        angle;
    logic signed [31:0]      t, opa, opb, addc, mres, sc;
    logic [31:0]             rnd;
    logic signed [SIN_W-1:0] sval;
    logic signed [47:0]      prod;
    logic                    put;

    assign o_valid     = r_ovalid;
    assign o_pop       = (r_state == BK_IDLE) && i_req_valid;
    assign put         = (r_state == BK_PUT) && (!r_ovalid || i_ready);
    assign k_comb      = K_W'(r_a) * K_W'(i_seg_count) + K_W'(r_b);

    // One restoring division step for each angle.
    always_comb begin
        sh1 = {r_rem1, r_d1[DIV_LEN-1]};
        sh2 = {r_rem2, r_d2[DIV_LEN-1]};
        dv1 = (REM_W+1)'(i_seg_count);
        dv2 = {1'b0, r_wn};
    end

    // Angle, operand selection and the shared Q30 multiply.
    always_comb begin
        unique case (r_sidx)
            2'd0: angle = r_q1;
            2'd1: angle = r_q1 + ANG_W'(1 << (ANG_W - 2));
            2'd2: angle = r_q2;
            default: angle = r_q2 + ANG_W'(1 << (ANG_W - 2));
        endcase
        t = 32'({angle[ANG_W-3:0], 16'd0});
        if (angle[ANG_W-2]) begin
            t = ONE_Q30 - t;
        end
        opa  = r_p;
        opb  = r_t2;
        addc = '0;
        case (r_step)
            3'd0: begin
                opa = t;
                opb = t;
            end
            3'd1: begin
                opa  = K9;
                addc = -K7;
            end
            3'd2: addc = K5;
            3'd3: addc = -K3;
            3'd4: addc = K1;
            default: opb = t;
        endcase
        mres = mul_q30(opa, opb) + addc;
        sc   = mres;
        if (mres < 0) begin
            sc = '0;
        end else if (mres > ONE_Q30) begin
            sc = ONE_Q30;
        end
        rnd  = (32'(sc) + 32'(1 << (29 - FRAC_W))) >> (30 - FRAC_W);
        sval = angle[ANG_W-1] ? -$signed(rnd[SIN_W-1:0]) : $signed(rnd[SIN_W-1:0]);
    end

    // Product for the output stages.
    always_comb begin
        case (r_state)
            BK_RAD:  prod = 48'($signed({1'b0, i_minor})) * 48'(r_sin[1]);
            BK_Y:    prod = 48'($signed({1'b0, i_minor})) * 48'(r_sin[0]);
            BK_X:    prod = 48'(r_r) * 48'(r_sin[2]);
            default: prod = 48'(r_r) * 48'(r_sin[3]);
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_req_valid) n_state = BK_LOAD;
            BK_LOAD: n_state = BK_DIV;
            BK_DIV:  if (r_cnt == 6'(DIV_LEN - 1)) n_state = BK_SIN;
            BK_SIN:  if (r_step == 3'd5 && r_sidx == 2'd3) n_state = BK_RAD;
            BK_RAD:  n_state = BK_Y;
            BK_Y:    n_state = BK_X;
            BK_X:    n_state = BK_Z;
            BK_Z:    n_state = BK_PUT;
            BK_PUT:  if (put) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_last <= i_req.last;
            end
            BK_LOAD: begin
                r_wn   <= REM_W'(i_wrap_count) * REM_W'(i_seg_count);
                r_d1   <= DIV_LEN'({r_b, 16'd0});
                r_d2   <= {k_comb, 16'd0};
                r_rem1 <= '0;
                r_rem2 <= '0;
                r_cnt  <= '0;
                r_sidx <= '0;
                r_step <= '0;
            end
            BK_DIV: begin
                r_d1  <= r_d1 << 1;
                r_d2  <= r_d2 << 1;
                r_cnt <= r_cnt + 1'b1;
                r_q1  <= {r_q1[ANG_W-2:0], sh1 >= dv1};
                r_q2  <= {r_q2[ANG_W-2:0], sh2 >= dv2};
                r_rem1 <= (sh1 >= dv1) ? REM_W'(sh1 - dv1) : REM_W'(sh1);
                r_rem2 <= (sh2 >= dv2) ? REM_W'(sh2 - dv2) : REM_W'(sh2);
            end
            BK_SIN: begin
                if (r_step == 3'd0) begin
                    r_t2 <= mres;
                end else if (r_step != 3'd5) begin
                    r_p <= mres;
                end
                if (r_step == 3'd5) begin
                    r_sin[r_sidx] <= sval;
                    r_step        <= '0;
                    r_sidx        <= r_sidx + 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            BK_RAD: r_r <= 32'({i_major, 12'd0}) + prod[31:0];
            BK_Y:   r_y <= sat_out((prod + 48'sd2048) >>> FRAC_W);
            BK_X:   r_x <= sat_out((prod + 48'sd8388608) >>> (2 * FRAC_W));
            BK_Z:   r_z <= sat_out((prod + 48'sd8388608) >>> (2 * FRAC_W));
            default: ;
        endcase
    end

    // Output register: holds a vertex until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (put) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put) begin
            o_pos_x     <= r_x;
            o_pos_y     <= r_y;
            o_pos_z     <= r_z;
            o_strip_end <= r_last;
        end
    end

endmodule

// ===== sv/torus_strip_vertex_generator_unit.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_ready  | i_restart
// output  | out       | o_valid / i_ready  | o_pos_x, o_pos_y, o_pos_z, o_strip_end
// config  | in        | APB psel / penable | paddr, pwdata, prdata
// In the back end, each vertex goes through bit-serial division for the two
// angles, the shared Q30 multiplier for four sines, and four output products.
// The front end keeps taking transfers into a two-entry queue while the back
// end works or its output waits.
// Reset is synchronous and active low and returns the strip to its first vertex.
module torus_strip_vertex_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_restart,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_x,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_y,
    output logic signed [tsvg_pkg::OUT_W-1:0] o_pos_z,
    output logic                              o_strip_end,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tsvg_pkg::*;

    logic [CNT_W-1:0] r_wrap, r_segs;
    logic [RAD_W-1:0] r_major, r_minor;
    logic             full, push, pop, nonempty;
    t_vtx_req         req_in, req_out;

    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap  <= 11'd10;
            r_segs  <= 11'd8;
            r_major <= 16'd12288;
            r_minor <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_WRAP:  r_wrap  <= clamp_count(pwdata, MAX_WRAPS);
                REG_SEGS:  r_segs  <= clamp_count(pwdata, MAX_SEGS);
                REG_MAJOR: r_major <= pwdata[RAD_W-1:0];
                REG_MINOR: r_minor <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_WRAP:  prdata = 32'(r_wrap);
            REG_SEGS:  prdata = 32'(r_segs);
            REG_MAJOR: prdata = 32'(r_major);
            default:   prdata = 32'(r_minor);
        endcase
    end

    tsvg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_restart    (i_restart),
        .i_wrap_count (r_wrap),
        .i_seg_count  (r_segs),
        .i_full       (full),
        .o_push       (push),
        .o_req        (req_in)
    );

    tsvg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req      (req_in),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_req      (req_out)
    );

    tsvg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (nonempty),
        .i_req        (req_out),
        .o_pop        (pop),
        .i_wrap_count (r_wrap),
        .i_seg_count  (r_segs),
        .i_major      (r_major),
        .i_minor      (r_minor),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_strip_end  (o_strip_end)
    );

endmodule

// ===== tb/torus_strip_vertex_generator_unit_test.sv =====
`timescale 1ns / 100ps

module torus_strip_vertex_generator_unit_test;
    import tsvg_pkg::*;

    // One expected vertex on the output channel.
    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    last;
    } t_vertex;

    // Row of the directed table: restart bit and, optionally, a typed-in vertex.
    typedef struct {
        logic    restart;
        logic    typed;
        t_vertex vtx;
    } t_row;

    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL   = 40;
    localparam longint ONE_Q30_L = 64'sd1 << 30;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_restart;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_pos_x;
    logic signed [OUT_W-1:0] o_pos_y;
    logic signed [OUT_W-1:0] o_pos_z;
    logic                    o_strip_end;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    torus_strip_vertex_generator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_restart(i_restart),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_strip_end(o_strip_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Mirror of the registers and of the strip position.
    logic [CNT_W-1:0] wraps_m;
    logic [CNT_W-1:0] segs_m;
    logic [RAD_W-1:0] major_m;
    logic [RAD_W-1:0] minor_m;
    int unsigned      wrap_pos;
    int unsigned      seg_pos;
    int unsigned      half_pos;
    int unsigned      closing_pos;

    t_vertex     pending_vertices[$];
    int          error_count;
    int          checked_count;
    int          strip_ends_seen;
    int          restarts_sent;
    bit          quiet;
    bit          stim_done;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // Product of two Q30 values, truncated toward zero.
    function automatic longint q30_product(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return p >>> 30;
        end
        return -((-p) >>> 30);
    endfunction

    // Shift right by k, rounding half toward plus infinity.
    function automatic longint round_half_up(input longint v, input int k);
        longint w;
        w = v + (64'sd1 <<< (k - 1));
        if (w >= 0) begin
            return w >>> k;
        end
        return -(((-w) + (64'sd1 <<< k) - 1) >>> k);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_coord(input longint v);
        if (v > 131071) begin
            return 18'sd131071;
        end else if (v < -131072) begin
            return -18'sd131072;
        end
        return v[OUT_W-1:0];
    endfunction

    // Sine of a 16-bit turn fraction, in Q1.12.
    function automatic longint turn_sine(input logic [ANG_W-1:0] ang);
        logic [1:0] quad;
        longint     t;
        longint     t2;
        longint     p;
        longint     s;
        longint     m;
        quad = ang[ANG_W-1 -: 2];
        t = longint'(ang[ANG_W-3:0]) <<< (32 - ANG_W);
        if (quad[0]) begin
            t = ONE_Q30_L - t;
        end
        t2 = q30_product(t, t);
        p = 172274;
        p = -5026994 + q30_product(p, t2);
        p = 85569306 + q30_product(p, t2);
        p = -693598669 + q30_product(p, t2);
        p = 1686629713 + q30_product(p, t2);
        s = q30_product(p, t);
        if (s < 0) begin
            s = 0;
        end
        if (s > ONE_Q30_L) begin
            s = ONE_Q30_L;
        end
        m = (s + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
        return quad[1] ? -m : m;
    endfunction

    // Coordinates of strip vertex (a, b) under the current registers.
    function automatic t_vertex torus_point(input longint a, input longint b,
                                            input logic last);
        t_vertex          v;
        longint           n;
        logic [ANG_W-1:0] phi;
        logic [ANG_W-1:0] theta;
        longint           sp;
        longint           cp;
        longint           st;
        longint           ct;
        longint           r;
        n = longint'(segs_m);
        phi = ANG_W'((b <<< ANG_W) / n);
        theta = ANG_W'(((a * n + b) <<< ANG_W) / (longint'(wraps_m) * n));
        sp = turn_sine(phi);
        cp = turn_sine(phi + 16'h4000);
        st = turn_sine(theta);
        ct = turn_sine(theta + 16'h4000);
        r = (longint'(major_m) <<< FRAC_W) + longint'(minor_m) * cp;
        v.x = clip_coord(round_half_up(r * st, 2 * FRAC_W));
        v.y = clip_coord(round_half_up(longint'(minor_m) * sp, FRAC_W));
        v.z = clip_coord(round_half_up(r * ct, 2 * FRAC_W));
        v.last = last;
        return v;
    endfunction

    // Advance the strip position for one transfer and return its vertex.
    function automatic t_vertex next_strip_vertex(input logic restart);
        t_vertex v;
        if (restart || closing_pos > 2) begin
            wrap_pos = 0; seg_pos = 0; half_pos = 0; closing_pos = 0;
        end
        if (closing_pos == 1) begin
            v = torus_point(0, 0, 1'b0);
            closing_pos = 2;
        end else if (closing_pos == 2) begin
            v = torus_point(1, 0, 1'b1);
            wrap_pos = 0; seg_pos = 0; half_pos = 0; closing_pos = 0;
        end else begin
            v = torus_point(wrap_pos + half_pos, seg_pos, 1'b0);
            if (half_pos == 0) begin
                half_pos = 1;
            end else begin
                half_pos = 0;
                seg_pos++;
                if (seg_pos >= segs_m) begin
                    seg_pos = 0;
                    wrap_pos++;
                    if (wrap_pos >= wraps_m) begin
                        wrap_pos = 0;
                        closing_pos = 1;
                    end
                end
            end
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] limit_count(input logic [31:0] v);
        if (v < 4) begin
            return 11'd4;
        end else if (v > 1024) begin
            return 11'd1024;
        end
        return v[CNT_W-1:0];
    endfunction

    // Write a register over APB, update the mirror, then read it back.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mirror;
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WRAP:  wraps_m = limit_count(value);
            REG_SEGS:  segs_m = limit_count(value);
            REG_MAJOR: major_m = value[RAD_W-1:0];
            default:   minor_m = value[RAD_W-1:0];
        endcase
        case (idx)
            REG_WRAP:  mirror = 32'(wraps_m);
            REG_SEGS:  mirror = 32'(segs_m);
            REG_MAJOR: mirror = 32'(major_m);
            default:   mirror = 32'(minor_m);
        endcase
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        if (prdata !== mirror) begin
            error_count++;
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, idx, mirror, prdata);
        end
    endtask

    // Offer one transfer on the input channel and wait for its acceptance.
    task automatic send_vertex_request(input logic restart);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_vertices.push_back(next_strip_vertex(restart));
        if (restart) begin
            restarts_sent++;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_vertices.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Output side: random stalls and the field-by-field check.
    initial begin
        int      stall;
        t_vertex want;
        stall = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_vertices.size() == 0) begin
                    error_count++;
                    $display("%0t: vertex transfer with none expected: x %0d y %0d z %0d",
                             $time, o_pos_x, o_pos_y, o_pos_z);
                end else begin
                    want = pending_vertices.pop_front();
                    checked_count++;
                    if (o_strip_end) begin
                        strip_ends_seen++;
                    end
                    if (o_pos_x !== want.x || o_pos_y !== want.y || o_pos_z !== want.z ||
                        o_strip_end !== want.last) begin
                        error_count++;
                        $display({"%0t: vertex mismatch expected %0d %0d %0d end %0b",
                                  " actual %0d %0d %0d end %0b"},
                                 $time, want.x, want.y, want.z, want.last,
                                 o_pos_x, o_pos_y, o_pos_z, o_strip_end);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        t_row        directed_rows[$];
        t_row        row;
        int          phase;
        int          items_in_phase;
        logic [31:0] wv;
        logic [31:0] nv;
        error_count = 0; checked_count = 0; strip_ends_seen = 0; restarts_sent = 0;
        quiet = 1'b0; stim_done = 1'b0;
        i_valid = 1'b0; i_restart = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        wraps_m = 11'd10; segs_m = 11'd8; major_m = 16'd12288; minor_m = 16'd4096;
        wrap_pos = 0; seg_pos = 0; half_pos = 0; closing_pos = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset settings: the first vertex is known
        // by hand (phi and theta zero, so z is R plus rm and x, y are zero).
        row.restart = 1'b1; row.typed = 1'b1;
        row.vtx = '{x: 18'sd0, y: 18'sd0, z: 18'sd16384, last: 1'b0};
        directed_rows.push_back(row);
        for (int k = 0; k < 19; k++) begin
            row.restart = (k == 11); row.typed = 1'b0;
            directed_rows.push_back(row);
        end
        foreach (directed_rows[k]) begin
            send_vertex_request(directed_rows[k].restart);
            if (directed_rows[k].typed) begin
                pending_vertices[$] = directed_rows[k].vtx;
            end
        end
        wait_drained();

        // Extremes: tiny strip with full-scale radii, then clamped counts.
        write_register(REG_WRAP, 32'd0);
        write_register(REG_SEGS, 32'd3);
        write_register(REG_MAJOR, 32'hFFFF);
        write_register(REG_MINOR, 32'hFFFF);
        send_vertex_request(1'b1);
        wait_drained();
        write_register(REG_WRAP, 32'hFFFF_FFFF);
        write_register(REG_SEGS, 32'd5000);
        write_register(REG_MAJOR, 32'd0);
        write_register(REG_MINOR, 32'd0);
        send_vertex_request(1'b0);
        send_vertex_request(1'b0);
        wait_drained();

        // Random phases; counts mostly small so the strip closes often, and
        // positions carry across phases so shrinking counts hits a live strip.
        phase = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                wait_drained();
                case (phase % 4)
                    0: begin wv = $urandom_range(4, 12); nv = $urandom_range(4, 12); end
                    1: begin wv = $urandom_range(0, 6); nv = $urandom_range(0, 6); end
                    2: begin wv = $urandom_range(13, 40); nv = $urandom_range(4, 9); end
                    default: begin wv = $urandom_range(4, 2047); nv = 1024; end
                endcase
                write_register(REG_WRAP, wv);
                write_register(REG_SEGS, nv);
                write_register(REG_MAJOR,
                               (phase % 3 == 0) ? 32'($urandom) : $urandom_range(0, 20000));
                write_register(REG_MINOR,
                               (phase % 3 == 1) ? 32'($urandom) : $urandom_range(0, 12000));
                phase++;
            end
            quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
            send_vertex_request($urandom_range(0, 59) == 0);
        end
        wait_drained();
        repeat (150) @(posedge i_clk);

        $display("Checked %0d vertices over %0d register settings, %0d strip ends, %0d restarts.",
                 checked_count, phase + 3, strip_ends_seen, restarts_sent);
        if (error_count == 0 && pending_vertices.size() == 0) begin
            $display("torus_strip_vertex_generator_unit test passed");
        end else begin
            $display("torus_strip_vertex_generator_unit test failed");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #8ms;
        $display("Timed out with %0d vertices outstanding.", pending_vertices.size());
        $display("torus_strip_vertex_generator_unit test failed");
        $finish;
    end

endmodule
